// ===== rtl/core/bgtg_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bgtg_pkg: shared types and constants
// Field widths, register indexes, channel codes, luma weights and reset
// values of the gray converter and flip address generator.
// ----------------------------------------------------------------------------
package bgtg_pkg;

    // Fixed field widths.
    localparam int CH_W        = 8;
    localparam int IDX_W       = 24;
    localparam int DIM_REG_W   = 13;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 13;
    localparam int LUMA_W      = 24;

    // Depth of the queue between the front and the back.
    localparam int QUEUE_DEPTH = 4;

    // Register indexes of the configuration port.
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_IMAGE_WIDTH    = 3'd0,
        CFG_IMAGE_HEIGHT   = 3'd1,
        CFG_FLIP_MODE      = 3'd2,
        CFG_CHANNEL_SELECT = 3'd3
    } cfg_index_e;

    // Channel selection codes.
    typedef enum logic [1:0] {
        CH_RED   = 2'd0,
        CH_GREEN = 2'd1,
        CH_BLUE  = 2'd2,
        CH_LUMA  = 2'd3
    } channel_e;

    // Bit positions inside the flip mode.
    localparam int FLIP_H_BIT = 0;
    localparam int FLIP_V_BIT = 1;

    // BT.601 luma weights in Q16.
    localparam logic [16:0] LUMA_R_WEIGHT = 17'd19595;
    localparam logic [16:0] LUMA_G_WEIGHT = 17'd38470;
    localparam logic [16:0] LUMA_B_WEIGHT = 17'd7471;

    // Reset values of the registers.
    localparam logic [DIM_REG_W-1:0] WIDTH_RESET  = 13'd640;
    localparam logic [DIM_REG_W-1:0] HEIGHT_RESET = 13'd480;
    localparam logic [1:0]           FLIP_RESET   = 2'd0;

    // One source pixel.
    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
    } pix_t;

    // Mode settings shared by the front and the back.
    typedef struct packed {
        logic [1:0] flip;
        channel_e   channel;
    } mode_t;

endpackage

// ===== rtl/core/bgtg_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bgtg_if: pixel and result channels
// Valid/ready channels for source pixels and for converted results.
// ----------------------------------------------------------------------------
interface bgtg_pix_if;
    logic                      valid;
    logic                      ready;
    logic [bgtg_pkg::CH_W-1:0] red;
    logic [bgtg_pkg::CH_W-1:0] green;
    logic [bgtg_pkg::CH_W-1:0] blue;

    modport source (output valid, output red, output green, output blue, input ready);
    modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

interface bgtg_res_if;
    logic                       valid;
    logic                       ready;
    logic [bgtg_pkg::CH_W-1:0]  gray_value;
    logic [bgtg_pkg::IDX_W-1:0] array_index;
    logic [bgtg_pkg::IDX_W-1:0] bitmap_index;
    logic                       last_pixel;

    modport source (output valid, output gray_value, output array_index,
                    output bitmap_index, output last_pixel, input ready);
    modport sink   (input valid, input gray_value, input array_index,
                    input bitmap_index, input last_pixel, output ready);
endinterface

// ===== rtl/core/bgtg_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bgtg_front: pixel intake and frame position
// Accepts pixels, walks the column and row counters and resolves the
// flipped coordinates of each item for the back end.
// ----------------------------------------------------------------------------
module bgtg_front #(
    parameter int MAX_DIM = 4096,
    parameter int CW      = $clog2(MAX_DIM),
    parameter int DW      = $clog2(MAX_DIM + 1)
) (
    input  logic                    clk,
    input  logic                    rst_n,
    bgtg_pix_if.sink                pixel,
    input  logic [DW-1:0]           width,
    input  logic [DW-1:0]           height,
    input  bgtg_pkg::mode_t         mode,
    input  logic                    queue_full,
    output logic                    push,
    output logic [3*CW+3*bgtg_pkg::CH_W:0] push_data
);

    typedef struct packed {
        bgtg_pkg::pix_t pix;
        logic [CW-1:0]  xa;
        logic [CW-1:0]  xb;
        logic [CW-1:0]  yy;
        logic           last;
    } desc_t;

    logic [CW-1:0] col_reg, col_next;
    logic [CW-1:0] row_reg, row_next;
    logic [DW-1:0] wm1_full, hm1_full;
    logic [CW-1:0] wm1, hm1, x, y, xr, yr;
    logic          end_row, last;
    desc_t         desc;

    // Dimension limits and clamped position.
    always_comb
    begin
        wm1_full = width - DW'(1);
        hm1_full = height - DW'(1);
        wm1      = wm1_full[CW-1:0];
        hm1      = hm1_full[CW-1:0];
        x        = (DW'(col_reg) < width)  ? col_reg : wm1;
        y        = (DW'(row_reg) < height) ? row_reg : hm1;
        xr       = wm1 - x;
        yr       = hm1 - y;
        end_row  = (x == wm1);
        last     = end_row && (y == hm1);
    end

    // Flipped coordinates of the item.
    always_comb
    begin
        desc.pix.red   = pixel.red;
        desc.pix.green = pixel.green;
        desc.pix.blue  = pixel.blue;
        desc.xa        = mode.flip[bgtg_pkg::FLIP_H_BIT] ? x : xr;
        desc.xb        = mode.flip[bgtg_pkg::FLIP_H_BIT] ? xr : x;
        desc.yy        = mode.flip[bgtg_pkg::FLIP_V_BIT] ? yr : y;
        desc.last      = last;
    end

    assign pixel.ready = !queue_full;
    assign push        = pixel.valid && !queue_full;
    assign push_data   = desc;

    // Counter advance after each accepted item.
    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (push)
        begin
            if (end_row)
            begin
                col_next = '0;
                row_next = last ? '0 : CW'(y + 1'b1);
            end
            else
            begin
                col_next = CW'(x + 1'b1);
                row_next = y;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

endmodule

// ===== rtl/core/bgtg_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bgtg_queue: short item queue
// A small first-in first-out buffer that decouples the front from the back.
// ----------------------------------------------------------------------------
module bgtg_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             full,
    output logic             empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] store_reg [DEPTH];
    logic [AW-1:0]    wr_reg, wr_next;
    logic [AW-1:0]    rd_reg, rd_next;
    logic [NW-1:0]    count_reg, count_next;
    logic             do_push, do_pop;

    assign full     = (count_reg == NW'(DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = store_reg[rd_reg];

    // Pointer and fill bookkeeping.
    always_comb
    begin
        wr_next    = wr_reg;
        rd_next    = rd_reg;
        count_next = count_reg;
        if (do_push)
        begin
            wr_next = (wr_reg == AW'(DEPTH - 1)) ? '0 : AW'(wr_reg + 1'b1);
        end
        if (do_pop)
        begin
            rd_next = (rd_reg == AW'(DEPTH - 1)) ? '0 : AW'(rd_reg + 1'b1);
        end
        if (do_push && !do_pop)
        begin
            count_next = NW'(count_reg + 1'b1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = NW'(count_reg - 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_reg    <= wr_next;
            rd_reg    <= rd_next;
            count_reg <= count_next;
        end
    end

    // Item storage.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            store_reg[wr_reg] <= push_data;
        end
    end

endmodule

// ===== rtl/core/bgtg_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bgtg_back: gray value and destination indices
// Two-stage pipeline: row offset multiply and channel selection, then the
// final index additions into the result register.
// ----------------------------------------------------------------------------
module bgtg_back #(
    parameter int MAX_DIM = 4096,
    parameter int CW      = $clog2(MAX_DIM),
    parameter int DW      = $clog2(MAX_DIM + 1)
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic [DW-1:0]                  width,
    input  logic [bgtg_pkg::IDX_W-1:0]     last_total,
    input  bgtg_pkg::mode_t                mode,
    input  logic                           queue_empty,
    input  logic [3*CW+3*bgtg_pkg::CH_W:0] pop_data,
    output logic                           pop,
    bgtg_res_if.source                     result
);

    localparam int IW = bgtg_pkg::IDX_W;

    typedef struct packed {
        bgtg_pkg::pix_t pix;
        logic [CW-1:0]  xa;
        logic [CW-1:0]  xb;
        logic [CW-1:0]  yy;
        logic           last;
    } desc_t;

    desc_t                       desc;
    logic                        adv;
    logic [bgtg_pkg::LUMA_W-1:0] luma;
    logic [bgtg_pkg::CH_W-1:0]   gray_sel;

    logic                        a_valid_reg;
    logic [IW-1:0]               a_prod_reg;
    logic [IW-1:0]               a_xa_reg;
    logic [IW-1:0]               a_xb_reg;
    logic [bgtg_pkg::CH_W-1:0]   a_gray_reg;
    logic                        a_last_reg;

    logic                        out_valid_reg;
    logic [bgtg_pkg::CH_W-1:0]   out_gray_reg;
    logic [IW-1:0]               out_array_reg;
    logic [IW-1:0]               out_bitmap_reg;
    logic                        out_last_reg;

    assign desc = pop_data;
    assign adv  = !out_valid_reg || result.ready;
    assign pop  = adv && !queue_empty;

    // Channel selection, with luma floored from the Q16 sum.
    always_comb
    begin
        luma = bgtg_pkg::LUMA_W'(bgtg_pkg::LUMA_R_WEIGHT * desc.pix.red)
             + bgtg_pkg::LUMA_W'(bgtg_pkg::LUMA_G_WEIGHT * desc.pix.green)
             + bgtg_pkg::LUMA_W'(bgtg_pkg::LUMA_B_WEIGHT * desc.pix.blue);
        case (mode.channel)
            bgtg_pkg::CH_RED:   gray_sel = desc.pix.red;
            bgtg_pkg::CH_GREEN: gray_sel = desc.pix.green;
            bgtg_pkg::CH_BLUE:  gray_sel = desc.pix.blue;
            default:            gray_sel = luma[bgtg_pkg::LUMA_W-1 -: bgtg_pkg::CH_W];
        endcase
    end

    // First stage: row offset and gray value.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            a_valid_reg <= !queue_empty;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_prod_reg <= IW'(width * desc.yy);
            a_xa_reg   <= IW'(desc.xa);
            a_xb_reg   <= IW'(desc.xb);
            a_gray_reg <= gray_sel;
            a_last_reg <= desc.last;
        end
    end

    // Second stage: index sums into the result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_gray_reg   <= a_gray_reg;
            out_array_reg  <= a_xa_reg + a_prod_reg;
            out_bitmap_reg <= last_total - (a_xb_reg + a_prod_reg);
            out_last_reg   <= a_last_reg;
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.gray_value   = out_gray_reg;
    assign result.array_index  = out_array_reg;
    assign result.bitmap_index = out_bitmap_reg;
    assign result.last_pixel   = out_last_reg;

endmodule

// ===== rtl/core/bgra_to_gray_flip_writer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bgra_to_gray_flip_writer: gray converter with flipped bitmap addressing
// Converts source pixels to gray values and gives each one its place in the
// gray sample array and in a 24-bit bitmap under the selected flip mode.
// ----------------------------------------------------------------------------
// The block takes one pixel per clock while its queue is not full and gives
// one result per clock while the output is ready; a result passes through the
// queue, the first stage register and the result register. The front
// resolves the frame position with registered column and row counters, a
// four-entry queue lets it keep accepting pixels while the output is stalled,
// and the back computes the row offset in its first stage and the indices in
// its second. Width and height of zero act as one and values above MAX_DIM
// act as MAX_DIM. Registers are to be written by the user only while no pixel
// is in flight; the block does not enforce it. The counters carry over a write.
module bgra_to_gray_flip_writer #(
    parameter int MAX_DIM = 4096
) (
    input  logic                                clk,
    input  logic                                rst_n,
    bgtg_pix_if.sink                            pixel,
    bgtg_res_if.source                          result,
    input  logic                                cfg_write,
    input  logic [bgtg_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [bgtg_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int CW     = $clog2(MAX_DIM);
    localparam int DW     = $clog2(MAX_DIM + 1);
    localparam int RW     = bgtg_pkg::DIM_REG_W;
    localparam int CMP_W  = (DW > RW) ? DW : RW;
    localparam int DESC_W = 3 * CW + 3 * bgtg_pkg::CH_W + 1;

    logic [RW-1:0]                width_reg;
    logic [RW-1:0]                height_reg;
    bgtg_pkg::mode_t              mode_reg;
    logic [bgtg_pkg::IDX_W-1:0]   total_reg;
    logic [CMP_W-1:0]             w_ext, h_ext;
    logic [DW-1:0]                width_eff, height_eff;

    logic                         push, pop, queue_full, queue_empty;
    logic [DESC_W-1:0]            push_data, pop_data;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg        <= bgtg_pkg::WIDTH_RESET;
            height_reg       <= bgtg_pkg::HEIGHT_RESET;
            mode_reg.flip    <= bgtg_pkg::FLIP_RESET;
            mode_reg.channel <= bgtg_pkg::CH_LUMA;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                bgtg_pkg::CFG_IMAGE_WIDTH:    width_reg        <= cfg_data[RW-1:0];
                bgtg_pkg::CFG_IMAGE_HEIGHT:   height_reg       <= cfg_data[RW-1:0];
                bgtg_pkg::CFG_FLIP_MODE:      mode_reg.flip    <= cfg_data[1:0];
                bgtg_pkg::CFG_CHANNEL_SELECT:
                    mode_reg.channel <= bgtg_pkg::channel_e'(cfg_data[1:0]);
                default: ;
            endcase
        end
    end

    // Effective dimensions: zero acts as one, oversize acts as the limit.
    always_comb
    begin
        w_ext = CMP_W'(width_reg);
        h_ext = CMP_W'(height_reg);
        if (w_ext == '0)
            width_eff = DW'(1);
        else if (w_ext > CMP_W'(MAX_DIM))
            width_eff = DW'(MAX_DIM);
        else
            width_eff = DW'(w_ext);
        if (h_ext == '0)
            height_eff = DW'(1);
        else if (h_ext > CMP_W'(MAX_DIM))
            height_eff = DW'(MAX_DIM);
        else
            height_eff = DW'(h_ext);
    end

    // Index of the final bitmap pixel, refreshed every cycle.
    always_ff @(posedge clk)
    begin
        total_reg <= bgtg_pkg::IDX_W'(width_eff * height_eff) - bgtg_pkg::IDX_W'(1);
    end

    bgtg_front #(
        .MAX_DIM (MAX_DIM)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .pixel      (pixel),
        .width      (width_eff),
        .height     (height_eff),
        .mode       (mode_reg),
        .queue_full (queue_full),
        .push       (push),
        .push_data  (push_data)
    );

    bgtg_queue #(
        .WIDTH (DESC_W),
        .DEPTH (bgtg_pkg::QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .full      (queue_full),
        .empty     (queue_empty)
    );

    bgtg_back #(
        .MAX_DIM (MAX_DIM)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .width       (width_eff),
        .last_total  (total_reg),
        .mode        (mode_reg),
        .queue_empty (queue_empty),
        .pop_data    (pop_data),
        .pop         (pop),
        .result      (result)
    );

endmodule
